[design/gf2e_pkg.sv]
// Shared types, field widths and codes for the GF(2) block encoder.
`default_nettype none

package gf2e_pkg;

  // Defaults for the code shape.
  localparam int DATA_BITS_DEF = 57;
  localparam int CODE_BITS_DEF = 63;

  // Fixed payload field widths.
  localparam int ROW_IDX_W = 6;
  localparam int ROW_W     = 63;
  localparam int CW_W      = 63;

  // Action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     row_bits;
    logic                 data_bit;
    logic                 end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [CW_W-1:0] codeword;
    logic            padded;
  } out_item_t;

  // Control carried alongside the row read into the accumulate stage.
  typedef struct packed {
    logic valid;
    logic bit_val;
    logic last;
    logic padded;
  } acc_ctrl_t;

endpackage

`default_nettype wire

[design/gf2e_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none

module gf2e_ram #(
  parameter int WIDTH = gf2e_pkg::CODE_BITS_DEF,
  parameter int DEPTH = gf2e_pkg::DATA_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/gf2e_accum.sv]
// Accumulate stage: XORs the read row into the codeword and holds the output register.
`default_nettype none

module gf2e_accum #(
  parameter int CODE_BITS = gf2e_pkg::CODE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gf2e_pkg::acc_ctrl_t   issue,
  input  wire logic [CODE_BITS-1:0]  rd_data,
  output logic                       adv,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output gf2e_pkg::out_item_t        out_data
);

  import gf2e_pkg::*;

  acc_ctrl_t       ctl_r, ctl_nxt;
  logic [CODE_BITS-1:0] acc_r, acc_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic [CODE_BITS-1:0] acc_sum;
  logic [CW_W-1:0]      cw_fit;
  logic                 emit;

  // Only a finishing beat can be blocked by a full output register.
  assign adv     = !(ctl_r.valid && ctl_r.last && out_valid_r && !out_ready);
  assign acc_sum = acc_r ^ (ctl_r.bit_val ? rd_data : '0);
  assign emit    = ctl_r.valid && ctl_r.last && adv;

  if (CODE_BITS >= CW_W) begin : g_cw_trunc
    assign cw_fit = acc_sum[CW_W-1:0];
  end else begin : g_cw_ext
    assign cw_fit = {{(CW_W-CODE_BITS){1'b0}}, acc_sum};
  end

  always_comb begin
    ctl_nxt       = ctl_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      ctl_nxt = issue;
      if (ctl_r.valid) begin
        acc_nxt = ctl_r.last ? '0 : acc_sum;
      end
    end
    if (emit) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.codeword = cw_fit;
      out_data_nxt.padded   = ctl_r.padded;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[design/gf2_generator_matrix_block_encoder_unit.sv]
// Top level of the GF(2) generator-matrix block encoder.
//
//  port group  | dir | handshake             | beat carries
//  ------------+-----+-----------------------+--------------------------------------
//  in_*        | in  | in_valid / in_ready   | load row (index, bits) or message bit
//  out_*       | out | out_valid / out_ready | codeword and padded flag
//
// One beat per cycle, loads and message bits alike. A message bit issues a
// row read from the generator RAM at its chunk position; the row comes back
// the next cycle and is XORed into the accumulator. A finishing bit's row is
// accumulated and the codeword then registered into the output register that
// drives out_valid. Reset clears the position counter, accumulator and output
// valid flag; generator rows are not cleared and must be loaded before use.
// in_ready drops only while a finishing bit waits behind an untaken result.
`default_nettype none

module gf2_generator_matrix_block_encoder_unit #(
  parameter int DATA_BITS = gf2e_pkg::DATA_BITS_DEF,
  parameter int CODE_BITS = gf2e_pkg::CODE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gf2e_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gf2e_pkg::out_item_t      out_data
);

  import gf2e_pkg::*;

  localparam int POS_W = $clog2(DATA_BITS);
  localparam logic [ROW_IDX_W:0]  ROW_LIM  = (ROW_IDX_W+1)'(DATA_BITS);
  localparam logic [POS_W-1:0]    POS_LAST = POS_W'(DATA_BITS - 1);

  // Position of the next message bit within its chunk.
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic                 in_fire;
  logic                 is_data;
  logic                 row_ok;
  logic                 pos_full;
  logic                 chunk_end;
  logic                 ram_we;
  logic                 ram_re;
  logic [POS_W-1:0]     ram_addr;
  logic [CODE_BITS-1:0] ram_wdata;
  logic [CODE_BITS-1:0] ram_rdata;
  logic                 adv;
  acc_ctrl_t            issue;

  assign in_ready  = adv;
  assign in_fire   = in_valid && in_ready;
  assign is_data   = (in_data.action == ACT_DATA);
  assign row_ok    = ({1'b0, in_data.row_index} < ROW_LIM);
  assign pos_full  = (pos_r == POS_LAST);
  assign chunk_end = pos_full || in_data.end_of_message;

  // Loads write their row; out-of-range rows are dropped.
  assign ram_we   = in_fire && !is_data && row_ok;
  assign ram_re   = in_fire && is_data;
  assign ram_addr = ram_we ? in_data.row_index[POS_W-1:0] : pos_r;

  // Row contents trimmed or widened to the code length.
  if (CODE_BITS <= ROW_W) begin : g_row_trunc
    assign ram_wdata = in_data.row_bits[CODE_BITS-1:0];
  end else begin : g_row_ext
    assign ram_wdata = {{(CODE_BITS-ROW_W){1'b0}}, in_data.row_bits};
  end

  // Control that follows the row read into the accumulate stage.
  always_comb begin
    issue.valid   = ram_re;
    issue.bit_val = in_data.data_bit;
    issue.last    = chunk_end;
    issue.padded  = !pos_full;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (ram_re) begin
      pos_nxt = chunk_end ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  gf2e_ram #(
    .WIDTH (CODE_BITS),
    .DEPTH (DATA_BITS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  gf2e_accum #(
    .CODE_BITS (CODE_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .rd_data   (ram_rdata),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Input stalls only behind an untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // Chunk position never reaches the chunk length.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("chunk position out of range");

  // A message end restarts the chunk.
  a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_data && in_data.end_of_message) |=> (pos_r == '0))
    else $error("chunk position not cleared after message end");

endmodule

`default_nettype wire
